// ===== src/ftd_pkg.sv =====
// Shared types, constants and membership set indexes for the fuzzy turn decision block.
`default_nettype none
package ftd_pkg;

    localparam int GRADE_BITS = 12;
    localparam int GW         = GRADE_BITS + 1;
    localparam logic [GW-1:0] GRADE_ONE = {1'b1, {GRADE_BITS{1'b0}}};

    localparam int DIST_W     = 16;
    localparam int ANG_W      = 15;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DIST_BND_W  = 16;
    localparam int DIST_TOL_W  = 15;
    localparam int DIR_TOL_W   = 13;
    localparam int SIDE_TOL_W  = 13;
    localparam int BND_ANG_W   = 14;
    localparam int ANG_TOL_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_DIST_BOUNDARY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_TOLERANCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_TOLERANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_ANGLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOLERANCE = 3'd5;

    localparam logic [DIST_BND_W-1:0] RST_DIST_BOUNDARY   = 16'd1024;
    localparam logic [DIST_TOL_W-1:0] RST_DIST_TOLERANCE  = 15'd256;
    localparam logic [DIR_TOL_W-1:0]  RST_DIR_TOLERANCE   = 13'd640;
    localparam logic [SIDE_TOL_W-1:0] RST_SIDE_TOLERANCE  = 13'd640;
    localparam logic [BND_ANG_W-1:0]  RST_BOUNDARY_ANGLE  = 14'd1920;
    localparam logic [ANG_TOL_W-1:0]  RST_ANGLE_TOLERANCE = 13'd320;

    // corner and coordinate arithmetic
    localparam int VW = 19;
    typedef logic signed [VW-1:0] t_val;
    localparam t_val DEG90   = 19'sd5760;
    localparam t_val DEG180  = 19'sd11520;
    localparam t_val VAL_MAX = {1'b0, {(VW-1){1'b1}}};

    // numerator and denominator width of one edge
    localparam int NW = 16;
    typedef logic [NW-1:0] t_num;

    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (GRADE_BITS + DIV_STEPS - 1) / DIV_STEPS;

    localparam int NTRAP      = 16;
    localparam int TR_LO_DIST = 0;
    localparam int TR_HI_DIST = 1;
    localparam int TR_IN      = 2;
    localparam int TR_BACK_A  = 3;
    localparam int TR_BACK_B  = 4;
    localparam int TR_OUT_A   = 5;
    localparam int TR_OUT_B   = 6;
    localparam int TR_LEFT_A  = 7;
    localparam int TR_LEFT_B  = 8;
    localparam int TR_RIGHT_A = 9;
    localparam int TR_RIGHT_B = 10;
    localparam int TR_ZERO    = 11;
    localparam int TR_LOW_A   = 12;
    localparam int TR_LOW_B   = 13;
    localparam int TR_HIGH_A  = 14;
    localparam int TR_HIGH_B  = 15;

    typedef struct packed {
        t_val a;
        t_val b;
        t_val c;
        t_val d;
    } t_corners;

    typedef t_corners [NTRAP-1:0] t_corner_tab;

    typedef struct packed {
        logic full;
        t_num num;
        t_num den;
    } t_edge;

    typedef t_edge [NTRAP-1:0] t_edge_vec;

    typedef logic [GW-1:0] t_grade;
    typedef t_grade [NTRAP-1:0] t_grade_vec;

    typedef enum logic [CMD_W-1:0] {
        CMD_LEFT  = 2'd0,
        CMD_RIGHT = 2'd1,
        CMD_NONE  = 2'd2
    } t_cmd;

endpackage
`default_nettype wire

// ===== src/ftd_in_if.sv =====
// Input channel carrying one sensor sample.
`default_nettype none
interface ftd_in_if;
    logic                               valid;
    logic                               ready;
    logic        [ftd_pkg::DIST_W-1:0]  distance;
    logic signed [ftd_pkg::ANG_W-1:0]   direction;
    logic signed [ftd_pkg::ANG_W-1:0]   side_angle;
    logic signed [ftd_pkg::ANG_W-1:0]   steer_angle;

    modport source (output valid, distance, direction, side_angle, steer_angle, input ready);
    modport sink   (input valid, distance, direction, side_angle, steer_angle, output ready);
endinterface
`default_nettype wire

// ===== src/ftd_out_if.sv =====
// Output channel carrying one turn decision with its rule strengths.
`default_nettype none
interface ftd_out_if;
    logic                         valid;
    logic                         ready;
    logic [ftd_pkg::CMD_W-1:0]    command;
    logic [ftd_pkg::GW-1:0]       left_strength;
    logic [ftd_pkg::GW-1:0]       right_strength;
    logic [ftd_pkg::GW-1:0]       straight_strength;

    modport source (output valid, command, left_strength, right_strength, straight_strength,
                    input ready);
    modport sink   (input valid, command, left_strength, right_strength, straight_strength,
                    output ready);
endinterface
`default_nettype wire

// ===== src/ftd_cfg.sv =====
// Configuration registers and the registered corner table of all membership sets.
`default_nettype none
module ftd_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ftd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [ftd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output      ftd_pkg::t_corner_tab               o_corners
);

    logic [ftd_pkg::DIST_BND_W-1:0] r_dist_bnd;
    logic [ftd_pkg::DIST_TOL_W-1:0] r_dist_tol;
    logic [ftd_pkg::DIR_TOL_W-1:0]  r_dir_tol;
    logic [ftd_pkg::SIDE_TOL_W-1:0] r_side_tol;
    logic [ftd_pkg::BND_ANG_W-1:0]  r_bnd_ang;
    logic [ftd_pkg::ANG_TOL_W-1:0]  r_ang_tol;

    ftd_pkg::t_corner_tab r_corners;
    ftd_pkg::t_corner_tab n_corners;

    ftd_pkg::t_val w_db;
    ftd_pkg::t_val w_dt;
    ftd_pkg::t_val w_rt;
    ftd_pkg::t_val w_st;
    ftd_pkg::t_val w_ba;
    ftd_pkg::t_val w_at;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_bnd <= ftd_pkg::RST_DIST_BOUNDARY;
            r_dist_tol <= ftd_pkg::RST_DIST_TOLERANCE;
            r_dir_tol  <= ftd_pkg::RST_DIR_TOLERANCE;
            r_side_tol <= ftd_pkg::RST_SIDE_TOLERANCE;
            r_bnd_ang  <= ftd_pkg::RST_BOUNDARY_ANGLE;
            r_ang_tol  <= ftd_pkg::RST_ANGLE_TOLERANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ftd_pkg::REG_DIST_BOUNDARY:   r_dist_bnd <= i_cfg_data[ftd_pkg::DIST_BND_W-1:0];
                ftd_pkg::REG_DIST_TOLERANCE:  r_dist_tol <= i_cfg_data[ftd_pkg::DIST_TOL_W-1:0];
                ftd_pkg::REG_DIR_TOLERANCE:   r_dir_tol  <= i_cfg_data[ftd_pkg::DIR_TOL_W-1:0];
                ftd_pkg::REG_SIDE_TOLERANCE:  r_side_tol <= i_cfg_data[ftd_pkg::SIDE_TOL_W-1:0];
                ftd_pkg::REG_BOUNDARY_ANGLE:  r_bnd_ang  <= i_cfg_data[ftd_pkg::BND_ANG_W-1:0];
                ftd_pkg::REG_ANGLE_TOLERANCE: r_ang_tol  <= i_cfg_data[ftd_pkg::ANG_TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_db = ftd_pkg::t_val'(r_dist_bnd);
    assign w_dt = ftd_pkg::t_val'(r_dist_tol);
    assign w_rt = ftd_pkg::t_val'(r_dir_tol);
    assign w_st = ftd_pkg::t_val'(r_side_tol);
    assign w_ba = ftd_pkg::t_val'(r_bnd_ang);
    assign w_at = ftd_pkg::t_val'(r_ang_tol);

    always_comb begin
        n_corners[ftd_pkg::TR_LO_DIST] = '{'0, '0, w_db - w_dt, w_db + w_dt};
        n_corners[ftd_pkg::TR_HI_DIST] = '{w_db - w_dt, w_db + w_dt,
                                           ftd_pkg::VAL_MAX, ftd_pkg::VAL_MAX};
        n_corners[ftd_pkg::TR_IN]      = '{-w_rt, w_rt,
                                           ftd_pkg::DEG90 - w_rt, ftd_pkg::DEG90 + w_rt};
        n_corners[ftd_pkg::TR_BACK_A]  = '{ftd_pkg::DEG90 - w_rt, ftd_pkg::DEG90 + w_rt,
                                           ftd_pkg::DEG180 - w_rt, ftd_pkg::DEG180 + w_rt};
        n_corners[ftd_pkg::TR_BACK_B]  = '{-ftd_pkg::DEG180 - w_rt, -ftd_pkg::DEG180 - w_rt,
                                           -ftd_pkg::DEG180 - w_rt, -ftd_pkg::DEG180 + w_rt};
        n_corners[ftd_pkg::TR_OUT_A]   = '{ftd_pkg::DEG180 - w_rt, ftd_pkg::DEG180 + w_rt,
                                           ftd_pkg::DEG180 + w_rt, ftd_pkg::DEG180 + w_rt};
        n_corners[ftd_pkg::TR_OUT_B]   = '{-ftd_pkg::DEG180 - w_rt, -ftd_pkg::DEG180 + w_rt,
                                           -w_rt, w_rt};
        n_corners[ftd_pkg::TR_LEFT_A]  = '{-ftd_pkg::DEG180, -ftd_pkg::DEG180,
                                           -ftd_pkg::DEG180, -ftd_pkg::DEG180 + w_st + w_st};
        n_corners[ftd_pkg::TR_LEFT_B]  = '{-w_st, w_st,
                                           ftd_pkg::DEG180 - w_st - w_st, ftd_pkg::DEG180};
        n_corners[ftd_pkg::TR_RIGHT_A] = '{ftd_pkg::DEG180 - w_st - w_st, ftd_pkg::DEG180,
                                           ftd_pkg::DEG180, ftd_pkg::DEG180};
        n_corners[ftd_pkg::TR_RIGHT_B] = '{-ftd_pkg::DEG180, -ftd_pkg::DEG180 + w_st + w_st,
                                           w_st, w_st};
        n_corners[ftd_pkg::TR_ZERO]    = '{-w_at, '0, '0, w_at};
        n_corners[ftd_pkg::TR_LOW_A]   = '{-w_ba - w_at, -w_ba + w_at, -w_at - w_at, '0};
        n_corners[ftd_pkg::TR_LOW_B]   = '{'0, w_at + w_at, w_ba - w_at, w_ba + w_at};
        n_corners[ftd_pkg::TR_HIGH_A]  = '{-ftd_pkg::DEG180, -ftd_pkg::DEG180,
                                           -w_ba - w_at, -w_ba + w_at};
        n_corners[ftd_pkg::TR_HIGH_B]  = '{w_ba - w_at, w_ba + w_at,
                                           ftd_pkg::DEG180, ftd_pkg::DEG180};
    end

    always_ff @(posedge i_clk) begin
        r_corners <= n_corners;
    end

    assign o_corners = r_corners;

endmodule
`default_nettype wire

// ===== src/ftd_classify.sv =====
// Input register and edge classification of every membership set.
`default_nettype none
module ftd_classify (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    ftd_in_if.sink                      i_item,
    input  wire ftd_pkg::t_corner_tab   i_corners,
    output      logic                   o_valid,
    input  wire logic                   i_ready,
    output      ftd_pkg::t_edge_vec     o_edges
);

    function automatic ftd_pkg::t_edge grade_edge(input ftd_pkg::t_val x,
                                                  input ftd_pkg::t_corners cr);
        ftd_pkg::t_edge e;
        ftd_pkg::t_val  a;
        ftd_pkg::t_val  b;
        ftd_pkg::t_val  c;
        ftd_pkg::t_val  d;
        ftd_pkg::t_val  v_n;
        ftd_pkg::t_val  v_d;
        a      = cr.a;
        b      = cr.b;
        c      = cr.c;
        d      = cr.d;
        e.full = 1'b0;
        v_n    = '0;
        v_d    = ftd_pkg::t_val'(1);
        if (x < a) begin
            v_n = '0;
        end else if (x < b) begin
            v_n = x - a;
            v_d = b - a;
        end else if (x <= c) begin
            e.full = 1'b1;
        end else if (x < d) begin
            v_n = d - x;
            v_d = d - c;
        end
        e.num = v_n[ftd_pkg::NW-1:0];
        e.den = v_d[ftd_pkg::NW-1:0];
        return e;
    endfunction

    logic                              r_v1;
    logic        [ftd_pkg::DIST_W-1:0] r_dist;
    logic signed [ftd_pkg::ANG_W-1:0]  r_dir;
    logic signed [ftd_pkg::ANG_W-1:0]  r_side;
    logic signed [ftd_pkg::ANG_W-1:0]  r_ang;

    logic               r_v2;
    ftd_pkg::t_edge_vec r_edges;
    ftd_pkg::t_edge_vec n_edges;

    logic w_en1;
    logic w_en2;

    assign w_en2        = !r_v2 || i_ready;
    assign w_en1        = !r_v1 || w_en2;
    assign i_item.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_item.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_dist <= i_item.distance;
            r_dir  <= i_item.direction;
            r_side <= i_item.side_angle;
            r_ang  <= i_item.steer_angle;
        end
        if (w_en2) begin
            r_edges <= n_edges;
        end
    end

    always_comb begin
        for (int k = 0; k < ftd_pkg::NTRAP; k++) begin
            if (k <= ftd_pkg::TR_HI_DIST) begin
                n_edges[k] = grade_edge(ftd_pkg::t_val'(r_dist), i_corners[k]);
            end else if (k <= ftd_pkg::TR_OUT_B) begin
                n_edges[k] = grade_edge(ftd_pkg::t_val'(r_dir), i_corners[k]);
            end else if (k <= ftd_pkg::TR_RIGHT_B) begin
                n_edges[k] = grade_edge(ftd_pkg::t_val'(r_side), i_corners[k]);
            end else begin
                n_edges[k] = grade_edge(ftd_pkg::t_val'(r_ang), i_corners[k]);
            end
        end
    end

    assign o_valid = r_v2;
    assign o_edges = r_edges;

endmodule
`default_nettype wire

// ===== src/ftd_div.sv =====
// Pipelined restoring dividers turning each edge position into a grade.
`default_nettype none
module ftd_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output      logic                 o_ready,
    input  wire ftd_pkg::t_edge_vec   i_edges,
    output      logic                 o_valid,
    input  wire logic                 i_ready,
    output      ftd_pkg::t_grade_vec  o_grades
);

    localparam int LAST = ftd_pkg::DIV_STAGES - 1;

    logic [ftd_pkg::DIV_STAGES-1:0] r_v;
    logic [ftd_pkg::DIV_STAGES:0]   w_en;
    logic [ftd_pkg::DIV_STAGES-1:0] w_vin;

    ftd_pkg::t_num                 r_rem  [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];
    ftd_pkg::t_num                 r_den  [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];
    logic [ftd_pkg::GRADE_BITS-1:0] r_q   [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];
    logic                          r_full [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];

    ftd_pkg::t_num                 n_rem  [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];
    ftd_pkg::t_num                 n_den  [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];
    logic [ftd_pkg::GRADE_BITS-1:0] n_q   [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];
    logic                          n_full [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];

    ftd_pkg::t_num                 w_rem_in  [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];
    ftd_pkg::t_num                 w_den_in  [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];
    logic [ftd_pkg::GRADE_BITS-1:0] w_q_in   [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];
    logic                          w_full_in [ftd_pkg::DIV_STAGES][ftd_pkg::NTRAP];

    always_comb begin
        w_en[ftd_pkg::DIV_STAGES] = i_ready;
        for (int s = LAST; s >= 0; s--) begin
            w_en[s] = !r_v[s] || w_en[s+1];
        end
    end

    assign o_ready = w_en[0];

    always_comb begin
        w_vin[0] = i_valid;
        for (int k = 0; k < ftd_pkg::NTRAP; k++) begin
            w_rem_in[0][k]  = i_edges[k].num;
            w_den_in[0][k]  = i_edges[k].den;
            w_q_in[0][k]    = '0;
            w_full_in[0][k] = i_edges[k].full;
        end
        for (int s = 1; s < ftd_pkg::DIV_STAGES; s++) begin
            w_vin[s] = r_v[s-1];
            for (int k = 0; k < ftd_pkg::NTRAP; k++) begin
                w_rem_in[s][k]  = r_rem[s-1][k];
                w_den_in[s][k]  = r_den[s-1][k];
                w_q_in[s][k]    = r_q[s-1][k];
                w_full_in[s][k] = r_full[s-1][k];
            end
        end
    end

    always_comb begin : p_step
        logic [ftd_pkg::NW:0]           v_wide;
        ftd_pkg::t_num                  v_rem;
        logic [ftd_pkg::GRADE_BITS-1:0] v_q;
        for (int s = 0; s < ftd_pkg::DIV_STAGES; s++) begin
            for (int k = 0; k < ftd_pkg::NTRAP; k++) begin
                v_rem = w_rem_in[s][k];
                v_q   = w_q_in[s][k];
                for (int j = 0; j < ftd_pkg::DIV_STEPS; j++) begin
                    if (s * ftd_pkg::DIV_STEPS + j < ftd_pkg::GRADE_BITS) begin
                        v_wide = {v_rem, 1'b0};
                        if (v_wide >= {1'b0, w_den_in[s][k]}) begin
                            v_wide = v_wide - {1'b0, w_den_in[s][k]};
                            v_q    = {v_q[ftd_pkg::GRADE_BITS-2:0], 1'b1};
                        end else begin
                            v_q    = {v_q[ftd_pkg::GRADE_BITS-2:0], 1'b0};
                        end
                        v_rem = v_wide[ftd_pkg::NW-1:0];
                    end
                end
                n_rem[s][k]  = v_rem;
                n_den[s][k]  = w_den_in[s][k];
                n_q[s][k]    = v_q;
                n_full[s][k] = w_full_in[s][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < ftd_pkg::DIV_STAGES; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= w_vin[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < ftd_pkg::DIV_STAGES; s++) begin
            if (w_en[s]) begin
                for (int k = 0; k < ftd_pkg::NTRAP; k++) begin
                    r_rem[s][k]  <= n_rem[s][k];
                    r_den[s][k]  <= n_den[s][k];
                    r_q[s][k]    <= n_q[s][k];
                    r_full[s][k] <= n_full[s][k];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < ftd_pkg::NTRAP; k++) begin
            o_grades[k] = r_full[LAST][k] ? ftd_pkg::GRADE_ONE : {1'b0, r_q[LAST][k]};
        end
    end

    assign o_valid = r_v[LAST];

endmodule
`default_nettype wire

// ===== src/ftd_rules.sv =====
// Compound sets, min/max rule evaluation and command selection with the output register.
`default_nettype none
module ftd_rules (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output      logic                  o_ready,
    input  wire ftd_pkg::t_grade_vec   i_grades,
    ftd_out_if.source                  o_result
);

    function automatic ftd_pkg::t_grade gmin(input ftd_pkg::t_grade a, input ftd_pkg::t_grade b);
        return (a < b) ? a : b;
    endfunction

    function automatic ftd_pkg::t_grade gmax(input ftd_pkg::t_grade a, input ftd_pkg::t_grade b);
        return (a > b) ? a : b;
    endfunction

    logic r_va;
    logic r_vb;
    logic r_vc;
    logic w_en_a;
    logic w_en_b;
    logic w_en_c;

    ftd_pkg::t_grade r_lo, r_hi, r_in, r_back, r_out, r_left, r_right, r_zero, r_low, r_high;
    ftd_pkg::t_grade r_nz;
    ftd_pkg::t_grade r_l, r_r, r_s;
    ftd_pkg::t_grade n_l, n_r, n_s;
    ftd_pkg::t_grade r_l_out, r_r_out, r_s_out;
    ftd_pkg::t_cmd   r_cmd;
    ftd_pkg::t_cmd   n_cmd;

    assign w_en_c  = !r_vc || o_result.ready;
    assign w_en_b  = !r_vb || w_en_c;
    assign w_en_a  = !r_va || w_en_b;
    assign o_ready = w_en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_va <= i_valid;
            end
            if (w_en_b) begin
                r_vb <= r_va;
            end
            if (w_en_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_lo    <= i_grades[ftd_pkg::TR_LO_DIST];
            r_hi    <= i_grades[ftd_pkg::TR_HI_DIST];
            r_in    <= i_grades[ftd_pkg::TR_IN];
            r_back  <= gmax(i_grades[ftd_pkg::TR_BACK_A], i_grades[ftd_pkg::TR_BACK_B]);
            r_out   <= gmax(i_grades[ftd_pkg::TR_OUT_A], i_grades[ftd_pkg::TR_OUT_B]);
            r_left  <= gmax(i_grades[ftd_pkg::TR_LEFT_A], i_grades[ftd_pkg::TR_LEFT_B]);
            r_right <= gmax(i_grades[ftd_pkg::TR_RIGHT_A], i_grades[ftd_pkg::TR_RIGHT_B]);
            r_zero  <= i_grades[ftd_pkg::TR_ZERO];
            r_low   <= gmax(i_grades[ftd_pkg::TR_LOW_A], i_grades[ftd_pkg::TR_LOW_B]);
            r_high  <= gmax(i_grades[ftd_pkg::TR_HIGH_A], i_grades[ftd_pkg::TR_HIGH_B]);
            r_nz    <= ftd_pkg::GRADE_ONE - i_grades[ftd_pkg::TR_ZERO];
        end
        if (w_en_b) begin
            r_l <= n_l;
            r_r <= n_r;
            r_s <= n_s;
        end
        if (w_en_c) begin
            r_l_out <= r_l;
            r_r_out <= r_r;
            r_s_out <= r_s;
            r_cmd   <= n_cmd;
        end
    end

    always_comb begin
        n_l = gmax(gmax(gmax(gmin(r_back, gmin(r_nz, r_left)),
                             gmin(gmin(r_hi, r_in), gmin(r_low, r_right))),
                        gmax(gmin(r_hi, gmin(r_out, r_right)),
                             gmin(r_hi, gmin(r_zero, r_right)))),
                   gmax(gmax(gmin(gmin(r_lo, r_in), gmin(r_low, r_left)),
                             gmin(gmin(r_lo, r_in), gmin(r_high, r_left))),
                        gmax(gmin(gmin(r_lo, r_out), gmin(r_low, r_right)),
                             gmin(gmin(r_lo, r_out), gmin(r_high, r_right)))));
        n_r = gmax(gmax(gmax(gmin(r_back, gmin(r_nz, r_right)),
                             gmin(gmin(r_hi, r_in), gmin(r_low, r_left))),
                        gmax(gmin(r_hi, gmin(r_out, r_left)),
                             gmin(r_hi, gmin(r_zero, r_left)))),
                   gmax(gmax(gmin(gmin(r_lo, r_in), gmin(r_low, r_right)),
                             gmin(gmin(r_lo, r_in), gmin(r_high, r_right))),
                        gmax(gmin(gmin(r_lo, r_out), gmin(r_low, r_left)),
                             gmin(gmin(r_lo, r_out), gmin(r_high, r_left)))));
        n_s = gmax(gmin(r_hi, gmin(r_in, r_high)), gmin(r_lo, r_zero));
    end

    always_comb begin
        if (r_l >= r_r && r_l >= r_s) begin
            n_cmd = ftd_pkg::CMD_LEFT;
        end else if (r_r >= r_l && r_r >= r_s) begin
            n_cmd = ftd_pkg::CMD_RIGHT;
        end else begin
            n_cmd = ftd_pkg::CMD_NONE;
        end
    end

    assign o_result.valid             = r_vc;
    assign o_result.command           = r_cmd;
    assign o_result.left_strength     = r_l_out;
    assign o_result.right_strength    = r_r_out;
    assign o_result.straight_strength = r_s_out;

endmodule
`default_nettype wire

// ===== src/fuzzy_turn_decision.sv =====
// Top level of the fuzzy turn decision block.
//
//  channel   dir  transfer            payload
//  i_item    in   valid & ready       distance, direction, side_angle, steer_angle
//  o_result  out  valid & ready       command, left/right/straight strength (Q1.12)
//  i_cfg_*   in   i_cfg_we            i_cfg_idx, i_cfg_data
//
// One sample per cycle unless o_result stalls; stages: input register, edge classification,
// three divider stages of four quotient bits each, compound sets, rules, output register.
// The divider pipeline sets the depth. Reset restores the register defaults and empties
// the pipeline. A full stage holds while the next holds; empty stages close up under stall.
`default_nettype none
module fuzzy_turn_decision (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ftd_in_if.sink                               i_item,
    ftd_out_if.source                            o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [ftd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ftd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ftd_pkg::t_corner_tab w_corners;
    ftd_pkg::t_edge_vec   w_edges;
    ftd_pkg::t_grade_vec  w_grades;
    logic                 w_cls_valid;
    logic                 w_div_ready;
    logic                 w_div_valid;
    logic                 w_rules_ready;

    ftd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_corners  (w_corners)
    );

    ftd_classify u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_corners (w_corners),
        .o_valid   (w_cls_valid),
        .i_ready   (w_div_ready),
        .o_edges   (w_edges)
    );

    ftd_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_cls_valid),
        .o_ready  (w_div_ready),
        .i_edges  (w_edges),
        .o_valid  (w_div_valid),
        .i_ready  (w_rules_ready),
        .o_grades (w_grades)
    );

    ftd_rules u_rules (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_div_valid),
        .o_ready  (w_rules_ready),
        .i_grades (w_grades),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ===== test/ftd_checker.sv =====
// Checker for the fuzzy turn decision block: grades each sample, predicts the decision, compares.
`default_nettype none
module ftd_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ftd_in_if.sink                               i_item,
    ftd_out_if.sink                              o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [ftd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ftd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import ftd_pkg::*;

    typedef struct packed {
        t_cmd           command;
        logic [GW-1:0]  left;
        logic [GW-1:0]  right;
        logic [GW-1:0]  straight;
    } t_decision;

    localparam longint ONE_G = longint'(1) << GRADE_BITS;
    localparam longint D90   = 5760;
    localparam longint D180  = 11520;

    t_decision decision_q[$];
    longint    dist_bnd, dist_tol, dir_tol, side_tol, bnd_ang, ang_tol;

    function automatic longint max2(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic longint min2(longint a, longint b);
        return a < b ? a : b;
    endfunction

    function automatic longint grade_trap(longint x, longint a, longint b, longint c,
                                          longint d);
        if (x < a) return 0;
        if (x < b) return ((x - a) * ONE_G) / (b - a);
        if (x <= c) return ONE_G;
        if (x < d) return ((d - x) * ONE_G) / (d - c);
        return 0;
    endfunction

    function automatic t_decision decide(longint dist_val, longint dir, longint side,
                                         longint ang);
        longint lo_d, hi_d, g_in, g_back, g_out, g_left, g_right, g_zero, g_low, g_high;
        longint nz, lt, rt, st, db, dt, r, s, ba, at;
        t_decision res;
        lt = 0; rt = 0; st = 0;
        db = dist_bnd; dt = dist_tol; r = dir_tol; s = side_tol; ba = bnd_ang; at = ang_tol;
        lo_d = grade_trap(dist_val, 0, 0, db - dt, db + dt);
        if (dist_val < db - dt) hi_d = 0;
        else if (dist_val < db + dt) hi_d = ((dist_val - (db - dt)) * ONE_G) / (2 * dt);
        else hi_d = ONE_G;
        g_in = grade_trap(dir, -r, r, D90 - r, D90 + r);
        g_back = max2(grade_trap(dir, D90 - r, D90 + r, D180 - r, D180 + r),
                      grade_trap(dir, -D180 - r, -D180 - r, -D180 - r, -D180 + r));
        g_out = max2(grade_trap(dir, D180 - r, D180 + r, D180 + r, D180 + r),
                     grade_trap(dir, -D180 - r, -D180 + r, -r, r));
        g_left = max2(grade_trap(side, -D180, -D180, -D180, -D180 + 2 * s),
                      grade_trap(side, -s, s, D180 - 2 * s, D180));
        g_right = max2(grade_trap(side, D180 - 2 * s, D180, D180, D180),
                       grade_trap(side, -D180, -D180 + 2 * s, s, s));
        g_zero = grade_trap(ang, -at, 0, 0, at);
        g_low = max2(grade_trap(ang, -ba - at, -ba + at, -2 * at, 0),
                     grade_trap(ang, 0, 2 * at, ba - at, ba + at));
        g_high = max2(grade_trap(ang, -D180, -D180, -ba - at, -ba + at),
                      grade_trap(ang, ba - at, ba + at, D180, D180));
        nz = ONE_G - g_zero;
        lt = max2(lt, min2(g_back, min2(nz, g_left)));
        rt = max2(rt, min2(g_back, min2(nz, g_right)));
        rt = max2(rt, min2(min2(hi_d, g_in), min2(g_low, g_left)));
        lt = max2(lt, min2(min2(hi_d, g_in), min2(g_low, g_right)));
        st = max2(st, min2(hi_d, min2(g_in, g_high)));
        rt = max2(rt, min2(hi_d, min2(g_out, g_left)));
        lt = max2(lt, min2(hi_d, min2(g_out, g_right)));
        rt = max2(rt, min2(hi_d, min2(g_zero, g_left)));
        lt = max2(lt, min2(hi_d, min2(g_zero, g_right)));
        lt = max2(lt, min2(min2(lo_d, g_in), min2(g_low, g_left)));
        lt = max2(lt, min2(min2(lo_d, g_in), min2(g_high, g_left)));
        rt = max2(rt, min2(min2(lo_d, g_in), min2(g_low, g_right)));
        rt = max2(rt, min2(min2(lo_d, g_in), min2(g_high, g_right)));
        rt = max2(rt, min2(min2(lo_d, g_out), min2(g_low, g_left)));
        lt = max2(lt, min2(min2(lo_d, g_out), min2(g_low, g_right)));
        rt = max2(rt, min2(min2(lo_d, g_out), min2(g_high, g_left)));
        lt = max2(lt, min2(min2(lo_d, g_out), min2(g_high, g_right)));
        st = max2(st, min2(lo_d, g_zero));
        if (lt >= rt && lt >= st) res.command = CMD_LEFT;
        else if (rt >= lt && rt >= st) res.command = CMD_RIGHT;
        else res.command = CMD_NONE;
        res.left = lt[GW-1:0];
        res.right = rt[GW-1:0];
        res.straight = st[GW-1:0];
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        $display("ftd_checker: mismatch %s got %0d want %0d", what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = decision_q.size();

    always @(posedge i_clk) begin
        t_decision want;
        if (!i_rst_n) begin
            dist_bnd = RST_DIST_BOUNDARY;
            dist_tol = RST_DIST_TOLERANCE;
            dir_tol  = RST_DIR_TOLERANCE;
            side_tol = RST_SIDE_TOLERANCE;
            bnd_ang  = RST_BOUNDARY_ANGLE;
            ang_tol  = RST_ANGLE_TOLERANCE;
            decision_q.delete();
        end else begin
            if (o_result.valid && o_result.ready) begin
                if (decision_q.size() == 0) begin
                    report("unexpected transfer", o_result.command, -1);
                end else begin
                    want = decision_q.pop_front();
                    if (o_result.command != want.command)
                        report("command", o_result.command, want.command);
                    if (o_result.left_strength != want.left)
                        report("left_strength", o_result.left_strength, want.left);
                    if (o_result.right_strength != want.right)
                        report("right_strength", o_result.right_strength, want.right);
                    if (o_result.straight_strength != want.straight)
                        report("straight_strength", o_result.straight_strength,
                               want.straight);
                end
            end
            if (i_item.valid && i_item.ready)
                decision_q.push_back(decide(longint'(i_item.distance),
                    longint'(i_item.direction), longint'(i_item.side_angle),
                    longint'(i_item.steer_angle)));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DIST_BOUNDARY:   dist_bnd = i_cfg_data[DIST_BND_W-1:0];
                    REG_DIST_TOLERANCE:  dist_tol = i_cfg_data[DIST_TOL_W-1:0];
                    REG_DIR_TOLERANCE:   dir_tol  = i_cfg_data[DIR_TOL_W-1:0];
                    REG_SIDE_TOLERANCE:  side_tol = i_cfg_data[SIDE_TOL_W-1:0];
                    REG_BOUNDARY_ANGLE:  bnd_ang  = i_cfg_data[BND_ANG_W-1:0];
                    REG_ANGLE_TOLERANCE: ang_tol  = i_cfg_data[ANG_TOL_W-1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Stimulus and verdict for the fuzzy turn decision block.
`default_nettype none
module tb_top;
    import ftd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    fail_count, pending;
    int                    send_idle_pct = 0, recv_stall_pct = 0;
    int                    hold_cycles = 0;
    int                    idle_cycles = 0;

    ftd_in_if  item_ch();
    ftd_out_if result_ch();

    fuzzy_turn_decision dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .o_result(result_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    ftd_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item_ch.sink), .o_result(result_ch.sink),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        item_ch.valid = 1'b0;
        item_ch.distance = '0;
        item_ch.direction = '0;
        item_ch.side_angle = '0;
        item_ch.steer_angle = '0;
        result_ch.ready = 1'b0;
    end

    // receiver: random stall, or a long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic [ANG_W-1:0] rand_angle();
        case ($urandom_range(9))
            0: return ANG_W'($urandom);
            1: return ANG_W'($urandom_range(23040)) - ANG_W'(11520);
            2: return ANG_W'($urandom_range(1200)) + ANG_W'(5160);
            3: return ANG_W'($urandom_range(1200)) - ANG_W'(600);
            4: return ANG_W'($urandom_range(1600)) + ANG_W'(10720);
            5: return ANG_W'(-11520) - ANG_W'($urandom_range(800)) + ANG_W'(400);
            default: return ANG_W'($urandom_range(6000)) - ANG_W'(3000);
        endcase
    endfunction

    task automatic send(logic [DIST_W-1:0] dist_val, logic [ANG_W-1:0] dir,
                        logic [ANG_W-1:0] side, logic [ANG_W-1:0] ang);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid = 1'b1;
        item_ch.distance <= dist_val;
        item_ch.direction <= dir;
        item_ch.side_angle <= side;
        item_ch.steer_angle <= ang;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
        item_ch.valid = 1'b0;
    endtask

    task automatic send_random();
        logic [DIST_W-1:0] dist_val;
        case ($urandom_range(3))
            0: dist_val = DIST_W'($urandom);
            1: dist_val = DIST_W'($urandom_range(3000));
            default: dist_val = DIST_W'($urandom_range(2048));
        endcase
        send(dist_val, rand_angle(), rand_angle(), rand_angle());
    endtask

    task automatic drain();
        item_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic configure(int db, int dt, int rt, int st, int ba, int at);
        write_reg(REG_DIST_BOUNDARY, CFG_DATA_W'(db));
        write_reg(REG_DIST_TOLERANCE, CFG_DATA_W'(dt));
        write_reg(REG_DIR_TOLERANCE, CFG_DATA_W'(rt));
        write_reg(REG_SIDE_TOLERANCE, CFG_DATA_W'(st));
        write_reg(REG_BOUNDARY_ANGLE, CFG_DATA_W'(ba));
        write_reg(REG_ANGLE_TOLERANCE, CFG_DATA_W'(at));
    endtask

    task automatic run_phase(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_random();
    endtask

    initial begin
        int phase;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes and special cases at reset settings
        send(16'd0, 15'sd0, 15'sd0, 15'sd0);
        send(16'hFFFF, 15'h3FFF, 15'h3FFF, 15'h3FFF);
        send(16'd768, 15'h4000, 15'h4000, 15'h4000);
        send(16'd1280, 15'sd5760, -15'sd11520, 15'sd1920);
        send(16'd1024, 15'sd11520, 15'sd11520, -15'sd1920);
        send(16'd900, -15'sd11520, 15'sd640, 15'sd320);
        send(16'd1100, -15'sd640, -15'sd640, -15'sd320);
        send(16'd2000, 15'sd6400, 15'sd10240, 15'sd2240);
        send(16'd500, 15'sd3000, -15'sd3000, 15'sd100);
        send(16'd1500, 15'sd11000, 15'sd0, 15'sd5000);
        drain();
        // zero widths act as steps
        configure(0, 0, 0, 0, 0, 0);
        send(16'd0, 15'sd0, 15'sd0, 15'sd0);
        send(16'd1, 15'sd5760, 15'sd11520, -15'sd11520);
        send(16'hFFFF, -15'sd11520, -15'sd11520, 15'sd11520);
        send(16'd0, 15'sd11520, 15'sd1, -15'sd1);
        run_phase(40, 0, 0);
        drain();
        // crossed corners with oversized registers, and unknown index
        configure(16'hFFFF, 16'h7FFF, 16'h1FFF, 16'h1FFF, 16'h3FFF, 16'h1FFF);
        write_reg(3'd6, 16'h1234);
        write_reg(3'd7, 16'hFFFF);
        send(16'hFFFF, 15'h3FFF, 15'h4000, 15'sd0);
        send(16'd0, 15'h4000, 15'h3FFF, 15'sd100);
        run_phase(60, 0, 0);
        drain();

        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: configure(1024, 256, 640, 640, 1920, 320);
                1: configure($urandom, $urandom, $urandom_range(5760),
                             $urandom_range(5760), $urandom_range(11520),
                             $urandom_range(5760));
                2: configure($urandom_range(3000), $urandom_range(600), $urandom_range(1500),
                             $urandom_range(1500), $urandom_range(4000),
                             $urandom_range(1000));
                default: configure(65535, 32767, 5760, 5760, 11520, 5760);
            endcase
            run_phase(40, 0, 0);
            run_phase(40, 64, 0);
            run_phase(40, 0, 64);
            run_phase(40, 23, 23);
            if (phase == 2) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                hold_cycles = 200;
                repeat (40) send_random();
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
src/ftd_pkg.sv
src/ftd_in_if.sv
src/ftd_out_if.sv
src/ftd_cfg.sv
src/ftd_classify.sv
src/ftd_div.sv
src/ftd_rules.sv
src/fuzzy_turn_decision.sv
test/ftd_checker.sv
test/tb_top.sv
